### design/ttb_pkg.sv
// Shared constants, codes and state type for the tick and timestamp timebase.
package ttb_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned PERIOD_W  = 30;
    localparam int unsigned RATE_W    = 34;
    localparam int unsigned MUL_W     = 30;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned MUL_STEPS = MUL_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned ADDR_W    = 4;

    localparam logic [MUL_W-1:0] NS_PER_SEC = 30'd1000000000;

    // register index as decoded from paddr[3]
    localparam logic CFG_PERIOD_IDX = 1'b0;
    localparam logic CFG_RATE_IDX   = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_SWITCH  = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_CONVERT = 2'd3
    } func_t;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_MULT  = 12'b000000000010,
        ST_SUB   = 12'b000000000100,
        ST_DIVQ  = 12'b000000001000,
        ST_MULW  = 12'b000000010000,
        ST_MULP  = 12'b000000100000,
        ST_DIVP  = 12'b000001000000,
        ST_ADDW  = 12'b000010000000,
        ST_ADDP  = 12'b000100000000,
        ST_DIVC  = 12'b001000000000,
        ST_ROUND = 12'b010000000000,
        ST_DONE  = 12'b100000000000
    } state_t;

endpackage

### design/tick_and_timestamp_timebase.sv
// Timebase top level: tick counter, timestamp anchor and ns conversions on one shared adder.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata: counter_value, duration_ns
//           |           |                    | tuser: func, from_boot_core
//  m_       | out       | m_tvalid/m_tready  | tdata: result_value, tick_total
//           |           |                    | tuser: on_counter_clock
//  apb      | in        | psel/penable       | 0x0 tick_period_ns, 0x8 counter_rate_hz
//
// Every transaction runs on one 65-bit adder under the sequencer: shift-add multiply
// and restoring divide. Tick, zero-rate switch and zero-period convert need no multiply
// or divide; switch and tick-derived read run one multiply; convert a divide and a round;
// counter-based read a subtract, divide, two multiplies, divide and two adds.
// aresetn is synchronous: it clears control, configuration, tick and anchor state, not
// the datapath registers. s_tready is high only when the sequencer is idle; a finished
// result waits in the output register, and a new transaction may be taken meanwhile.
module tick_and_timestamp_timebase (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [127:0]                     s_tdata,   // counter_value, duration_ns
    input  logic [2:0]                       s_tuser,   // func[1:0], from_boot_core
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [127:0]                     m_tdata,   // result_value, tick_total
    output logic                             m_tuser,   // on_counter_clock
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ttb_pkg::ADDR_W-1:0]       paddr,
    input  logic [ttb_pkg::CFG_W-1:0]        pwdata,
    output logic [ttb_pkg::CFG_W-1:0]        prdata,
    output logic                             pready
);

    localparam int unsigned W  = ttb_pkg::WORD_W;
    localparam int unsigned PW = ttb_pkg::PERIOD_W;
    localparam int unsigned RW = ttb_pkg::RATE_W;
    localparam int unsigned MW = ttb_pkg::MUL_W;
    localparam int unsigned SW = ttb_pkg::STEP_W;

    ttb_pkg::state_t state_reg, state_next;
    ttb_pkg::func_t  func_reg, func_next;

    logic [PW-1:0] period_reg;
    logic [RW-1:0] rate_cfg_reg;
    logic [W-1:0]  tick_reg, tick_next;
    logic [W-1:0]  anchor_cnt_reg, anchor_cnt_next;
    logic [W-1:0]  anchor_ns_reg, anchor_ns_next;
    logic [RW-1:0] active_rate_reg, active_rate_next;

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  mcand_reg, mcand_next;
    logic [MW-1:0] mplier_reg, mplier_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] divisor_reg, divisor_next;
    logic [W-1:0]  save_reg, save_next;
    logic [W-1:0]  res_reg, res_next;
    logic [SW-1:0] step_reg, step_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [W-1:0]  m_result_reg, m_result_next;
    logic [W-1:0]  m_tick_reg, m_tick_next;
    logic          m_clock_reg, m_clock_next;

    // shared adder
    logic [W-1:0]  add_a, add_b;
    logic          add_cin;
    logic [W:0]    add_sum;

    logic [RW:0]   div_trial;
    logic          div_fit;
    logic [RW-1:0] div_rem;
    logic [W-1:0]  div_acc;
    logic [W-1:0]  mul_acc;
    logic          mul_last, div_last;
    logic          cfg_wr;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ttb_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_tick_reg, m_result_reg};
    assign m_tuser  = m_clock_reg;
    assign cfg_wr   = psel & penable & pwrite & pready;

    always_comb begin
        if (paddr[3] == ttb_pkg::CFG_RATE_IDX) begin
            prdata = {{(ttb_pkg::CFG_W-RW){1'b0}}, rate_cfg_reg};
        end else begin
            prdata = {{(ttb_pkg::CFG_W-PW){1'b0}}, period_reg};
        end
    end

    assign div_trial = {rem_reg, acc_reg[W-1]};
    assign mul_last  = (step_reg == SW'(ttb_pkg::MUL_STEPS - 1));
    assign div_last  = (step_reg == SW'(ttb_pkg::DIV_STEPS - 1));

    // operand selection for the shared adder
    always_comb begin
        add_a   = tick_reg;
        add_b   = '0;
        add_cin = 1'b1;
        case (state_reg)
            ttb_pkg::ST_MULT, ttb_pkg::ST_MULW, ttb_pkg::ST_MULP: begin
                add_a   = acc_reg;
                add_b   = mplier_reg[0] ? mcand_reg : '0;
                add_cin = 1'b0;
            end
            ttb_pkg::ST_DIVQ, ttb_pkg::ST_DIVP, ttb_pkg::ST_DIVC: begin
                add_a   = {{(W-RW-1){1'b0}}, div_trial};
                add_b   = ~{{(W-RW){1'b0}}, divisor_reg};
                add_cin = 1'b1;
            end
            ttb_pkg::ST_SUB: begin
                add_a   = save_reg;
                add_b   = ~anchor_cnt_reg;
                add_cin = 1'b1;
            end
            ttb_pkg::ST_ADDW: begin
                add_a   = anchor_ns_reg;
                add_b   = save_reg;
                add_cin = 1'b0;
            end
            ttb_pkg::ST_ADDP: begin
                add_a   = save_reg;
                add_b   = acc_reg;
                add_cin = 1'b0;
            end
            ttb_pkg::ST_ROUND: begin
                add_a   = acc_reg;
                add_b   = '0;
                add_cin = |rem_reg;
            end
            default: begin
                add_a   = tick_reg;
                add_b   = '0;
                add_cin = 1'b1;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_cin};
    assign div_fit = add_sum[W];
    assign div_rem = div_fit ? add_sum[RW-1:0] : div_trial[RW-1:0];
    assign div_acc = {acc_reg[W-2:0], div_fit};
    assign mul_acc = add_sum[W-1:0];

    always_comb begin
        state_next       = state_reg;
        func_next        = func_reg;
        tick_next        = tick_reg;
        anchor_cnt_next  = anchor_cnt_reg;
        anchor_ns_next   = anchor_ns_reg;
        active_rate_next = active_rate_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        rem_next         = rem_reg;
        divisor_next     = divisor_reg;
        save_next        = save_reg;
        res_next         = res_reg;
        step_next        = step_reg;
        m_tvalid_next    = m_tvalid_reg & ~m_tready;
        m_result_next    = m_result_reg;
        m_tick_next      = m_tick_reg;
        m_clock_next     = m_clock_reg;

        case (state_reg)
            ttb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    func_next = ttb_pkg::func_t'(s_tuser[1:0]);
                    save_next = s_tdata[W-1:0];
                    step_next = '0;
                    res_next  = '0;
                    case (ttb_pkg::func_t'(s_tuser[1:0]))
                        ttb_pkg::FUNC_TICK: begin
                            if (s_tuser[2]) begin
                                tick_next = add_sum[W-1:0];
                            end
                            state_next = ttb_pkg::ST_DONE;
                        end
                        ttb_pkg::FUNC_SWITCH: begin
                            if (rate_cfg_reg == '0) begin
                                state_next = ttb_pkg::ST_DONE;
                            end else begin
                                acc_next    = '0;
                                mcand_next  = tick_reg;
                                mplier_next = period_reg;
                                state_next  = ttb_pkg::ST_MULT;
                            end
                        end
                        ttb_pkg::FUNC_READ: begin
                            if (active_rate_reg == '0) begin
                                acc_next    = '0;
                                mcand_next  = tick_reg;
                                mplier_next = period_reg;
                                state_next  = ttb_pkg::ST_MULT;
                            end else begin
                                state_next  = ttb_pkg::ST_SUB;
                            end
                        end
                        default: begin
                            if (period_reg == '0) begin
                                res_next   = s_tdata[2*W-1:W];
                                state_next = ttb_pkg::ST_DONE;
                            end else begin
                                acc_next     = s_tdata[2*W-1:W];
                                rem_next     = '0;
                                divisor_next = {{(RW-PW){1'b0}}, period_reg};
                                state_next   = ttb_pkg::ST_DIVC;
                            end
                        end
                    endcase
                end
            end
            ttb_pkg::ST_MULT: begin
                acc_next    = mul_acc;
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MW-1:1]};
                step_next   = step_reg + SW'(1);
                if (mul_last) begin
                    if (func_reg == ttb_pkg::FUNC_SWITCH) begin
                        anchor_cnt_next  = save_reg;
                        anchor_ns_next   = mul_acc;
                        active_rate_next = rate_cfg_reg;
                    end else begin
                        res_next = mul_acc;
                    end
                    state_next = ttb_pkg::ST_DONE;
                end
            end
            ttb_pkg::ST_SUB: begin
                // clamp a lagging reading to zero delta
                acc_next     = add_sum[W] ? add_sum[W-1:0] : '0;
                rem_next     = '0;
                divisor_next = active_rate_reg;
                step_next    = '0;
                state_next   = ttb_pkg::ST_DIVQ;
            end
            ttb_pkg::ST_DIVQ: begin
                acc_next  = div_acc;
                rem_next  = div_rem;
                step_next = step_reg + SW'(1);
                if (div_last) begin
                    acc_next    = '0;
                    mcand_next  = div_acc;
                    mplier_next = ttb_pkg::NS_PER_SEC;
                    save_next   = {{(W-RW){1'b0}}, div_rem};
                    step_next   = '0;
                    state_next  = ttb_pkg::ST_MULW;
                end
            end
            ttb_pkg::ST_MULW: begin
                acc_next    = mul_acc;
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MW-1:1]};
                step_next   = step_reg + SW'(1);
                if (mul_last) begin
                    // hold the whole-second term, start on the remainder
                    acc_next    = '0;
                    mcand_next  = save_reg;
                    mplier_next = ttb_pkg::NS_PER_SEC;
                    save_next   = mul_acc;
                    step_next   = '0;
                    state_next  = ttb_pkg::ST_MULP;
                end
            end
            ttb_pkg::ST_MULP: begin
                acc_next    = mul_acc;
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MW-1:1]};
                step_next   = step_reg + SW'(1);
                if (mul_last) begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ttb_pkg::ST_DIVP;
                end
            end
            ttb_pkg::ST_DIVP: begin
                acc_next  = div_acc;
                rem_next  = div_rem;
                step_next = step_reg + SW'(1);
                if (div_last) begin
                    state_next = ttb_pkg::ST_ADDW;
                end
            end
            ttb_pkg::ST_ADDW: begin
                save_next  = add_sum[W-1:0];
                state_next = ttb_pkg::ST_ADDP;
            end
            ttb_pkg::ST_ADDP: begin
                res_next   = add_sum[W-1:0];
                state_next = ttb_pkg::ST_DONE;
            end
            ttb_pkg::ST_DIVC: begin
                acc_next  = div_acc;
                rem_next  = div_rem;
                step_next = step_reg + SW'(1);
                if (div_last) begin
                    state_next = ttb_pkg::ST_ROUND;
                end
            end
            ttb_pkg::ST_ROUND: begin
                // round up when a remainder is left
                res_next   = add_sum[W-1:0];
                state_next = ttb_pkg::ST_DONE;
            end
            ttb_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_result_next = res_reg;
                    m_tick_next   = tick_reg;
                    m_clock_next  = (active_rate_reg != '0);
                    state_next    = ttb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ttb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ttb_pkg::ST_IDLE;
            func_reg        <= ttb_pkg::FUNC_TICK;
            m_tvalid_reg    <= 1'b0;
            period_reg      <= '0;
            rate_cfg_reg    <= '0;
            tick_reg        <= '0;
            anchor_cnt_reg  <= '0;
            anchor_ns_reg   <= '0;
            active_rate_reg <= '0;
            step_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            m_tvalid_reg    <= m_tvalid_next;
            tick_reg        <= tick_next;
            anchor_cnt_reg  <= anchor_cnt_next;
            anchor_ns_reg   <= anchor_ns_next;
            active_rate_reg <= active_rate_next;
            step_reg        <= step_next;
            if (cfg_wr) begin
                if (paddr[3] == ttb_pkg::CFG_RATE_IDX) begin
                    rate_cfg_reg <= pwdata[RW-1:0];
                end else begin
                    period_reg <= pwdata[PW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_next_hold: begin
            acc_reg      <= acc_next;
            mcand_reg    <= mcand_next;
            mplier_reg   <= mplier_next;
            rem_reg      <= rem_next;
            divisor_reg  <= divisor_next;
            save_reg     <= save_next;
            res_reg      <= res_next;
            m_result_reg <= m_result_next;
            m_tick_reg   <= m_tick_next;
            m_clock_reg  <= m_clock_next;
        end
    end

endmodule
